// ===== hw/rtl/dpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsd_pkg
// Shared types and constants for the dual pressure spike detector.
// ----------------------------------------------------------------------------
package dpsd_pkg;

    localparam int PRESSURE_W = 16;   // width of a pressure field on the port
    localparam int RATIO_W    = 6;    // spike ratio register, in tenths
    localparam int TENTHS     = 10;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [RATIO_W-1:0]   RATIO_RESET     = 6'd12;
    localparam logic [REG_IDX_W-1:0] REG_SPIKE_RATIO = 1'd0;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_CLOSE_OWN = 2'd1,
        ACT_SHUTDOWN  = 2'd2
    } action_t;

endpackage

// ===== hw/rtl/dpsd_channel.sv =====
// ----------------------------------------------------------------------------
// dpsd_channel
// One pressure channel: sample window, running sum and spike compare.
// ----------------------------------------------------------------------------
module dpsd_channel #(
    parameter int WINDOW_LENGTH = 5,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              upd,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic [dpsd_pkg::RATIO_W-1:0]      ratio,
    output logic                              hit
);
    import dpsd_pkg::*;

    localparam int FILL_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int IDX_W   = $clog2(WINDOW_LENGTH);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LENGTH + 1);
    localparam int SCALE   = WINDOW_LENGTH * TENTHS;
    localparam int SCALE_W = $clog2(SCALE + 1) + 1;
    localparam int CMP_W   = SUM_W + RATIO_W + SCALE_W + 1;
    localparam int LAST    = WINDOW_LENGTH - 1;

    logic signed [SAMPLE_BITS-1:0] win_reg [WINDOW_LENGTH];
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic                          full;
    logic signed [CMP_W-1:0]       samp_x;
    logic signed [CMP_W-1:0]       sum_x;
    logic signed [CMP_W-1:0]       scale_x;
    logic signed [CMP_W-1:0]       ratio_x;
    logic signed [CMP_W-1:0]       lhs;
    logic signed [CMP_W-1:0]       rhs;

    assign full = (fill_reg == FILL_W'(WINDOW_LENGTH));

    // window * 10 * sample > ratio * sum, compared against the sum before this sample
    assign samp_x  = CMP_W'(sample);
    assign sum_x   = CMP_W'(sum_reg);
    assign scale_x = CMP_W'(SCALE);
    assign ratio_x = CMP_W'({1'b0, ratio});
    assign lhs     = samp_x * scale_x;
    assign rhs     = ratio_x * sum_x;
    assign hit     = full && (lhs > rhs);

    // running sum: first sample restarts it, a full window drops its oldest entry
    always_comb begin
        fill_next = fill_reg;
        if (full) begin
            sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(sample);
        end else if (fill_reg == '0) begin
            sum_next  = SUM_W'(sample);
            fill_next = fill_reg + 1'b1;
        end else begin
            sum_next  = sum_reg + SUM_W'(sample);
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (upd) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            sum_reg <= sum_next;
            if (full) begin
                for (int i = 0; i < LAST; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[LAST] <= sample;
            end else begin
                win_reg[fill_reg[IDX_W-1:0]] <= sample;
            end
        end
    end

endmodule

// ===== hw/rtl/dual_pressure_spike_detector.sv =====
// ----------------------------------------------------------------------------
// dual_pressure_spike_detector
// Moving-average spike detector for the oxidizer and fuel injector pressures.
//
//   channel   direction  ports                                   handshake
//   s_        in         lox/prop pressure, lox/prop valve open  s_valid/s_ready
//   m_        out        lox/prop spike, lox/prop action         m_valid/m_ready
//   config    in         apb: psel penable pwrite paddr pwdata   pready tied high
//
// one item per cycle sustained while m_ready stays high; each accepted item passes
// through the input register, then compare and window update into the result
// register, which drives m_valid.
// the window sum is kept as a running register, so the per-item path is the sum
// update, a constant by sample multiply and a 6-bit by sum multiply into a compare.
// synchronous active-low reset clears valids and fill counts and reloads the ratio.
// s_ready drops only while both registers hold an item and m_ready is low.
// ----------------------------------------------------------------------------
module dual_pressure_spike_detector #(
    parameter int WINDOW_LENGTH = 5,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dpsd_pkg::PRESSURE_W-1:0] s_lox_pressure,
    input  logic signed [dpsd_pkg::PRESSURE_W-1:0] s_prop_pressure,
    input  logic                                s_lox_valve_open,
    input  logic                                s_prop_valve_open,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_lox_spike,
    output logic [1:0]                          m_lox_action,
    output logic                                m_prop_spike,
    output logic [1:0]                          m_prop_action,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpsd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dpsd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dpsd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import dpsd_pkg::*;

    logic [RATIO_W-1:0]            ratio_reg;
    logic [REG_IDX_W-1:0]          reg_idx;

    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic signed [SAMPLE_BITS-1:0] lox_samp_reg;
    logic signed [SAMPLE_BITS-1:0] prop_samp_reg;
    logic                          lox_open_reg;
    logic                          prop_open_reg;
    logic signed [SAMPLE_BITS-1:0] lox_samp;
    logic signed [SAMPLE_BITS-1:0] prop_samp;

    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic                          lox_spike_reg;
    logic                          prop_spike_reg;
    action_t                       lox_act_reg;
    action_t                       prop_act_reg;
    action_t                       lox_act;
    action_t                       prop_act;

    logic                          s_fire;
    logic                          advance;
    logic                          lox_hit_raw;
    logic                          prop_hit_raw;
    logic                          lox_hit;
    logic                          prop_hit;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign prdata  = (reg_idx == REG_SPIKE_RATIO) ? CFG_DATA_W'(ratio_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
        end else if (psel && penable && pwrite && pready && reg_idx == REG_SPIKE_RATIO) begin
            ratio_reg <= pwdata[RATIO_W-1:0];
        end
    end

    // low SAMPLE_BITS of the field; wider samples take the field zero extended
    generate
        if (SAMPLE_BITS <= PRESSURE_W) begin : g_narrow
            assign lox_samp  = s_lox_pressure[SAMPLE_BITS-1:0];
            assign prop_samp = s_prop_pressure[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign lox_samp  = {{(SAMPLE_BITS-PRESSURE_W){1'b0}}, s_lox_pressure};
            assign prop_samp = {{(SAMPLE_BITS-PRESSURE_W){1'b0}}, s_prop_pressure};
        end
    endgenerate

    // two-stage flow control
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || !out_vld_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lox_samp_reg  <= lox_samp;
            prop_samp_reg <= prop_samp;
            lox_open_reg  <= s_lox_valve_open;
            prop_open_reg <= s_prop_valve_open;
        end
    end

    dpsd_channel #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_lox (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (advance && lox_open_reg),
        .sample  (lox_samp_reg),
        .ratio   (ratio_reg),
        .hit     (lox_hit_raw)
    );

    dpsd_channel #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_prop (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (advance && prop_open_reg),
        .sample  (prop_samp_reg),
        .ratio   (ratio_reg),
        .hit     (prop_hit_raw)
    );

    // a closed valve gives no spike; the other valve decides the action
    assign lox_hit  = lox_open_reg && lox_hit_raw;
    assign prop_hit = prop_open_reg && prop_hit_raw;

    always_comb begin
        lox_act = ACT_NONE;
        if (lox_hit) begin
            lox_act = prop_open_reg ? ACT_CLOSE_OWN : ACT_SHUTDOWN;
        end
        prop_act = ACT_NONE;
        if (prop_hit) begin
            prop_act = lox_open_reg ? ACT_CLOSE_OWN : ACT_SHUTDOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lox_spike_reg  <= lox_hit;
            prop_spike_reg <= prop_hit;
            lox_act_reg    <= lox_act;
            prop_act_reg   <= prop_act;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_lox_spike   = lox_spike_reg;
    assign m_prop_spike  = prop_spike_reg;
    assign m_lox_action  = lox_act_reg;
    assign m_prop_action = prop_act_reg;

endmodule

// ===== hw/rtl/dpsd_checker.sv =====
// ----------------------------------------------------------------------------
// dpsd_checker
// Port-level checks for the dual pressure spike detector, bound to the top.
// ----------------------------------------------------------------------------
module dpsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_lox_spike,
    input logic [1:0] m_lox_action,
    input logic       m_prop_spike,
    input logic [1:0] m_prop_action
);
    import dpsd_pkg::*;

    // no item comes out right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lox_spike) && $stable(m_lox_action)
            && $stable(m_prop_spike) && $stable(m_prop_action))
        else $error("stalled result changed");

    a_lox_action_iff_spike: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_lox_spike == (m_lox_action != ACT_NONE))
        else $error("oxidizer action does not match spike");

    a_prop_action_iff_spike: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_prop_spike == (m_prop_action != ACT_NONE))
        else $error("fuel action does not match spike");

    // both spiking means both valves were open
    a_both_close_own: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lox_spike && m_prop_spike |->
            m_lox_action == ACT_CLOSE_OWN && m_prop_action == ACT_CLOSE_OWN)
        else $error("double spike asked for shutdown");

endmodule

bind dual_pressure_spike_detector dpsd_checker u_dpsd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_lox_spike   (m_lox_spike),
    .m_lox_action  (m_lox_action),
    .m_prop_spike  (m_prop_spike),
    .m_prop_action (m_prop_action)
);

// ===== dv/tb_dual_pressure_spike_detector.sv =====
// ----------------------------------------------------------------------------
// tb_dual_pressure_spike_detector
// Self-checking bench for the dual pressure spike detector. A queue-fed driver
// sends sample pairs in random bursts, the receiver stalls on its own pattern,
// and a monitor predicts each report from its own copy of both moving windows
// and the spike ratio, then checks every result field. The ratio register is
// swept over its extremes, fixed mid values and random values through the APB port while idle.
// ----------------------------------------------------------------------------
module tb_dual_pressure_spike_detector;

    import dpsd_pkg::*;

    localparam int WINDOW_LENGTH = 5;
    localparam int SAMPLE_BITS   = 16;
    localparam int LOX_CH        = 0;
    localparam int PROP_CH       = 1;
    localparam int ITEMS_PER_PHASE = 160;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'd1;

    typedef logic signed [PRESSURE_W-1:0] pressure_t;

    typedef struct packed {
        pressure_t lox_pressure;
        pressure_t prop_pressure;
        logic      lox_open;
        logic      prop_open;
    } sample_pair_t;

    typedef struct packed {
        logic    lox_spike;
        action_t lox_action;
        logic    prop_spike;
        action_t prop_action;
    } spike_report_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    pressure_t s_lox_pressure = '0;
    pressure_t s_prop_pressure = '0;
    logic      s_lox_valve_open = 1'b0;
    logic      s_prop_valve_open = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_lox_spike;
    logic [1:0] m_lox_action;
    logic       m_prop_spike;
    logic [1:0] m_prop_action;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    dual_pressure_spike_detector #(
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_lox_pressure   (s_lox_pressure),
        .s_prop_pressure  (s_prop_pressure),
        .s_lox_valve_open (s_lox_valve_open),
        .s_prop_valve_open(s_prop_valve_open),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lox_spike      (m_lox_spike),
        .m_lox_action     (m_lox_action),
        .m_prop_spike     (m_prop_spike),
        .m_prop_action    (m_prop_action),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // predictor state: both moving windows, their fill levels and the ratio
    pressure_t        window_mem [2][WINDOW_LENGTH];
    int unsigned      fill_level [2] = '{0, 0};
    logic [RATIO_W-1:0] ratio_tenths = RATIO_RESET;

    sample_pair_t  pending_pairs [$];
    spike_report_t expected_reports [$];

    int mismatch_count   = 0;
    int items_checked    = 0;
    int lox_spike_count  = 0;
    int prop_spike_count = 0;
    int shutdown_count   = 0;
    int ratio_settings   = 1;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // one open channel: test against the window mean, then shift the sample in
    function automatic logic channel_update(input int ch, input pressure_t pres);
        longint window_sum;
        logic   hit;
        hit = 1'b0;
        if (fill_level[ch] >= WINDOW_LENGTH) begin
            window_sum = 0;
            for (int i = 0; i < WINDOW_LENGTH; i++)
                window_sum += longint'(window_mem[ch][i]);
            hit = (longint'(WINDOW_LENGTH * TENTHS) * longint'(pres)) >
                  (longint'(ratio_tenths) * window_sum);
            for (int i = 0; i < WINDOW_LENGTH - 1; i++)
                window_mem[ch][i] = window_mem[ch][i + 1];
            window_mem[ch][WINDOW_LENGTH - 1] = pres;
        end else begin
            window_mem[ch][fill_level[ch]] = pres;
            fill_level[ch]++;
        end
        return hit;
    endfunction

    function automatic spike_report_t predict_report(input sample_pair_t pair);
        spike_report_t rep;
        rep.lox_spike  = pair.lox_open  ? channel_update(LOX_CH, pair.lox_pressure)   : 1'b0;
        rep.prop_spike = pair.prop_open ? channel_update(PROP_CH, pair.prop_pressure) : 1'b0;
        rep.lox_action  = !rep.lox_spike  ? ACT_NONE :
                          (pair.prop_open ? ACT_CLOSE_OWN : ACT_SHUTDOWN);
        rep.prop_action = !rep.prop_spike ? ACT_NONE :
                          (pair.lox_open  ? ACT_CLOSE_OWN : ACT_SHUTDOWN);
        return rep;
    endfunction

    // driver: bursts of random length separated by random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    sample_pair_t next_pair;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0 || pending_pairs.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end else begin
                next_pair = pending_pairs.pop_front();
                s_valid           <= 1'b1;
                s_lox_pressure    <= next_pair.lox_pressure;
                s_prop_pressure   <= next_pair.prop_pressure;
                s_lox_valve_open  <= next_pair.lox_open;
                s_prop_valve_open <= next_pair.prop_open;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 3) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: switches between no stalls, light stalls and heavy stalls
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_span <= $urandom_range(20, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 99) >= 25);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 99) >= 75);
                end
            endcase
        end
    end

    // monitor: check results first, then predict the item accepted at this edge
    spike_report_t want;
    sample_pair_t  taken_pair;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result spike=%b/%b action=%0d/%0d", $time,
                             m_lox_spike, m_prop_spike, m_lox_action, m_prop_action);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    items_checked++;
                    if (m_lox_spike !== want.lox_spike) begin
                        $display("%0t: lox_spike expected %b actual %b",
                                 $time, want.lox_spike, m_lox_spike);
                        mismatch_count++;
                    end
                    if (m_lox_action !== want.lox_action) begin
                        $display("%0t: lox_action expected %0d actual %0d",
                                 $time, want.lox_action, m_lox_action);
                        mismatch_count++;
                    end
                    if (m_prop_spike !== want.prop_spike) begin
                        $display("%0t: prop_spike expected %b actual %b",
                                 $time, want.prop_spike, m_prop_spike);
                        mismatch_count++;
                    end
                    if (m_prop_action !== want.prop_action) begin
                        $display("%0t: prop_action expected %0d actual %0d",
                                 $time, want.prop_action, m_prop_action);
                        mismatch_count++;
                    end
                    if (want.lox_spike)
                        lox_spike_count++;
                    if (want.prop_spike)
                        prop_spike_count++;
                    if (want.lox_action == ACT_SHUTDOWN || want.prop_action == ACT_SHUTDOWN)
                        shutdown_count++;
                end
            end
            if (s_valid && s_ready) begin
                taken_pair.lox_pressure  = s_lox_pressure;
                taken_pair.prop_pressure = s_prop_pressure;
                taken_pair.lox_open      = s_lox_valve_open;
                taken_pair.prop_open     = s_prop_valve_open;
                expected_reports.push_back(predict_report(taken_pair));
            end
        end
    end

    task automatic push_pair(input pressure_t lox, input pressure_t prop,
                             input logic lox_open, input logic prop_open);
        sample_pair_t pair;
        pair.lox_pressure  = lox;
        pair.prop_pressure = prop;
        pair.lox_open      = lox_open;
        pair.prop_open     = prop_open;
        pending_pairs.push_back(pair);
    endtask

    // mostly a steady level with noise, some spikes, some raw random words
    function automatic pressure_t pick_pressure(input int level);
        int     pick;
        longint value;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return pressure_t'($urandom());
        if (pick < 22)
            value = longint'(level) * $urandom_range(2, 9) + $urandom_range(0, 200);
        else
            value = longint'(level) + $signed($urandom_range(0, 64)) - 32;
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        return pressure_t'(value);
    endfunction

    function automatic int pick_level();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return -int'($urandom_range(100, 8000));
        if (pick == 1)
            return $urandom_range(0, 60);
        return $urandom_range(200, 6000);
    endfunction

    task automatic queue_random_pairs(input int count);
        int lox_level;
        int prop_level;
        lox_level  = pick_level();
        prop_level = pick_level();
        @(negedge aclk);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0)
                lox_level = pick_level();
            if ($urandom_range(0, 49) == 0)
                prop_level = pick_level();
            push_pair(pick_pressure(lox_level), pick_pressure(prop_level),
                      $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_pairs.size() != 0 || s_valid || expected_reports.size() != 0);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SPIKE_RATIO)
            ratio_tenths = data[RATIO_W-1:0];
    endtask

    task automatic check_ratio_readback();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_SPIKE_RATIO, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[RATIO_W-1:0] !== ratio_tenths) begin
            $display("%0t: spike ratio readback expected %0d actual %0d",
                     $time, ratio_tenths, prdata[RATIO_W-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic run_ratio_phase(input logic [RATIO_W-1:0] ratio);
        logic [31:0] word;
        // junk in the unused upper bits should not matter
        word = $urandom();
        word[RATIO_W-1:0] = ratio;
        apb_write(REG_SPIKE_RATIO, word);
        ratio_settings++;
        check_ratio_readback();
        queue_random_pairs(ITEMS_PER_PHASE);
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        check_ratio_readback();

        @(negedge aclk);
        // valves closed: extremes are ignored and windows stay empty
        push_pair(16'sh7fff, -16'sh8000, 1'b0, 1'b0);
        push_pair(-16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        // filling both windows, no test while not full
        for (int n = 0; n < WINDOW_LENGTH; n++)
            push_pair(16'sd100, 16'sd100, 1'b1, 1'b1);
        // right at the threshold for lox, just above it for prop
        push_pair(16'sd120, 16'sd121, 1'b1, 1'b1);
        // both spike in one item: each closes its own valve
        push_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
        // lone spikes ask for full shutdown
        push_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
        push_pair(16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
        // closed valve between samples leaves the window untouched
        push_pair(16'sd5, 16'sd5, 1'b0, 1'b0);
        push_pair(-16'sh8000, -16'sh8000, 1'b1, 1'b1);
        push_pair(16'sd0, -16'sd1, 1'b1, 1'b1);
        push_pair(16'sd1, 16'sd2, 1'b1, 1'b1);
        push_pair(16'sh7fff, -16'sh8000, 1'b1, 1'b1);
        wait_drained();

        // zero ratio flags any positive sample over a full window
        run_ratio_phase(6'd0);
        run_ratio_phase(6'd63);
        // write to an unmapped register must leave the ratio alone
        apb_write(REG_UNMAPPED, $urandom());
        check_ratio_readback();
        run_ratio_phase(6'd10);
        run_ratio_phase(6'd40);
        run_ratio_phase(RATIO_RESET);
        for (int k = 0; k < 2; k++)
            run_ratio_phase(RATIO_W'($urandom_range(0, 63)));

        repeat (8) @(posedge aclk);
        $display("checked %0d results over %0d ratio settings", items_checked, ratio_settings);
        $display("spikes seen: %0d oxidizer, %0d fuel, %0d with a shutdown request",
                 lox_spike_count, prop_spike_count, shutdown_count);
        if (mismatch_count == 0)
            $display("tb_dual_pressure_spike_detector: PASS");
        else
            $display("tb_dual_pressure_spike_detector: FAIL");
        $finish;
    end

    initial begin
        #600000;
        $display("timeout with %0d results still expected", expected_reports.size());
        $display("tb_dual_pressure_spike_detector: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dpsd_pkg.sv
hw/rtl/dpsd_channel.sv
hw/rtl/dual_pressure_spike_detector.sv
hw/rtl/dpsd_checker.sv
dv/tb_dual_pressure_spike_detector.sv
